// ===== src/bounded_deque_bag_assert.svh =====
// Assertion macros shared by the deque/bag RTL.
`ifndef BOUNDED_DEQUE_BAG_ASSERT_SVH
`define BOUNDED_DEQUE_BAG_ASSERT_SVH

// General form: explicit clock and active-low reset.
`define BDB_ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Shorthand for modules clocked by i_clk and reset by i_rst_n.
`define BDB_ASSERT(label, prop, msg) `BDB_ASSERT_ON(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== src/bdb_pkg.sv =====
// Package with the types, codes, ring helper and microcode table of the deque/bag.
package bdb_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int UPC_W   = 4;

    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic [CNT_W:0]            t_sum;
    typedef logic [COUNT_W-1:0]        t_count;
    typedef logic [OP_W-1:0]           t_op;
    typedef logic [STAT_W-1:0]         t_status;
    typedef logic signed [DATA_W-1:0]  t_data;
    typedef logic [UPC_W-1:0]          t_upc;

    // Operation codes of a request.
    localparam t_op OP_ADD_FRONT = 3'd0;
    localparam t_op OP_ADD_BACK  = 3'd1;
    localparam t_op OP_REM_FRONT = 3'd2;
    localparam t_op OP_REM_BACK  = 3'd3;
    localparam t_op OP_CONTAINS  = 3'd4;
    localparam t_op OP_REM_VALUE = 3'd5;

    // Result status codes.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Microprogram addresses.
    localparam t_upc U_ADDF    = 4'd0;
    localparam t_upc U_ADDB    = 4'd1;
    localparam t_upc U_REMF    = 4'd2;
    localparam t_upc U_REMB    = 4'd3;
    localparam t_upc U_FULL    = 4'd4;
    localparam t_upc U_EMPTY   = 4'd5;
    localparam t_upc U_SRCH0   = 4'd6;
    localparam t_upc U_SRCH    = 4'd7;
    localparam t_upc U_SRCHX   = 4'd8;
    localparam t_upc U_FIN_RF  = 4'd9;
    localparam t_upc U_FIN_RB  = 4'd10;
    localparam t_upc U_FIN_OUT = 4'd11;
    localparam t_upc U_SHIFT   = 4'd12;

    // Store read selection.
    typedef enum logic [2:0] {
        RD_NONE  = 3'd0,
        RD_IDX   = 3'd1,
        RD_IDX1  = 3'd2,
        RD_IDX2  = 3'd3,
        RD_FRONT = 3'd4,
        RD_BACK  = 3'd5
    } t_rd;

    // Store write selection.
    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_FRONT = 2'd1,
        WR_BACK  = 2'd2,
        WR_SHIFT = 2'd3
    } t_wr;

    // Datapath action.
    typedef enum logic [3:0] {
        ACT_NONE   = 4'd0,
        ACT_PUSH_F = 4'd1,
        ACT_PUSH_B = 4'd2,
        ACT_POP_F  = 4'd3,
        ACT_POP_B  = 4'd4,
        ACT_FULL   = 4'd5,
        ACT_EMPTY  = 4'd6,
        ACT_CMP    = 4'd7,
        ACT_SHIFT  = 4'd8,
        ACT_CAP_F  = 4'd9,
        ACT_OUT    = 4'd10
    } t_act;

    // Jump condition.
    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_SRCH_END  = 3'd2,
        C_DEL_HIT   = 3'd3,
        C_SHIFT_END = 3'd4,
        C_OUT_FREE  = 3'd5
    } t_cond;

    // One control word: if cond holds jump to target, else stay when loop, else step on.
    typedef struct packed {
        t_rd   rd;
        t_wr   wr;
        t_act  act;
        t_cond cond;
        logic  loop;
        t_upc  target;
    } t_uword;

    // Ring position of the entry at a given offset from the head.
    function automatic t_idx ring_pos(t_idx head, t_cnt off);
        t_sum sum;
        sum = t_sum'(head) + t_sum'(off);
        if (sum >= t_sum'(DEPTH)) begin
            sum = sum - t_sum'(DEPTH);
        end
        return t_idx'(sum);
    endfunction

    // Entry point of the microprogram for a new request.
    function automatic t_upc dispatch(t_op op, logic empty, logic full);
        t_upc start;
        unique case (op) inside
            OP_ADD_FRONT: start = full ? U_FULL : U_ADDF;
            OP_ADD_BACK:  start = full ? U_FULL : U_ADDB;
            OP_REM_FRONT: start = empty ? U_EMPTY : U_REMF;
            OP_REM_BACK:  start = empty ? U_EMPTY : U_REMB;
            OP_CONTAINS, OP_REM_VALUE: start = empty ? U_EMPTY : U_SRCH0;
            default:      start = U_FIN_RF;
        endcase
        return start;
    endfunction

    // Microcode table.
    function automatic t_uword ucode(t_upc upc);
        t_uword w;
        unique case (upc)
            U_ADDF: w = '{rd: RD_NONE, wr: WR_FRONT, act: ACT_PUSH_F, cond: C_ALWAYS,
                          loop: 1'b0, target: U_FIN_RF};
            U_ADDB: w = '{rd: RD_NONE, wr: WR_BACK, act: ACT_PUSH_B, cond: C_ALWAYS,
                          loop: 1'b0, target: U_FIN_RF};
            U_REMF: w = '{rd: RD_NONE, wr: WR_NONE, act: ACT_POP_F, cond: C_ALWAYS,
                          loop: 1'b0, target: U_FIN_RF};
            U_REMB: w = '{rd: RD_NONE, wr: WR_NONE, act: ACT_POP_B, cond: C_ALWAYS,
                          loop: 1'b0, target: U_FIN_RF};
            U_FULL: w = '{rd: RD_NONE, wr: WR_NONE, act: ACT_FULL, cond: C_ALWAYS,
                          loop: 1'b0, target: U_FIN_RF};
            U_EMPTY: w = '{rd: RD_NONE, wr: WR_NONE, act: ACT_EMPTY, cond: C_ALWAYS,
                           loop: 1'b0, target: U_FIN_RF};
            U_SRCH0: w = '{rd: RD_IDX, wr: WR_NONE, act: ACT_NONE, cond: C_NEVER,
                           loop: 1'b0, target: U_SRCH};
            U_SRCH: w = '{rd: RD_IDX1, wr: WR_NONE, act: ACT_CMP, cond: C_SRCH_END,
                          loop: 1'b1, target: U_SRCHX};
            U_SRCHX: w = '{rd: RD_NONE, wr: WR_NONE, act: ACT_NONE, cond: C_DEL_HIT,
                           loop: 1'b0, target: U_SHIFT};
            U_FIN_RF: w = '{rd: RD_FRONT, wr: WR_NONE, act: ACT_NONE, cond: C_NEVER,
                            loop: 1'b0, target: U_FIN_RB};
            U_FIN_RB: w = '{rd: RD_BACK, wr: WR_NONE, act: ACT_CAP_F, cond: C_NEVER,
                            loop: 1'b0, target: U_FIN_OUT};
            U_FIN_OUT: w = '{rd: RD_NONE, wr: WR_NONE, act: ACT_OUT, cond: C_OUT_FREE,
                             loop: 1'b1, target: U_FIN_RF};
            U_SHIFT: w = '{rd: RD_IDX2, wr: WR_SHIFT, act: ACT_SHIFT, cond: C_SHIFT_END,
                           loop: 1'b1, target: U_FIN_RF};
            default: w = '{rd: RD_NONE, wr: WR_NONE, act: ACT_NONE, cond: C_ALWAYS,
                           loop: 1'b0, target: U_FIN_RF};
        endcase
        return w;
    endfunction

endpackage

// ===== src/bdb_if.sv =====
// Request and response channel interfaces of the deque/bag.
interface bdb_req_if;
    logic                valid;
    logic                ready;
    bdb_pkg::t_op        op;
    bdb_pkg::t_data      value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface bdb_rsp_if;
    logic                valid;
    logic                ready;
    bdb_pkg::t_status    status;
    logic                found;
    bdb_pkg::t_data      front_value;
    bdb_pkg::t_data      back_value;
    bdb_pkg::t_count     count;

    modport source (output valid, output status, output found, output front_value,
                    output back_value, output count, input ready);
    modport sink (input valid, input status, input found, input front_value,
                  input back_value, input count, output ready);
endinterface

// ===== src/bdb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bounded_deque_bag.sv =====
// Top level of the bounded deque/bag: microcode sequencer, datapath and entry store.
//
// Usage: requests arrive on i_req (op, value) and each gives exactly one
// response on o_rsp (status, found, front_value, back_value, count). Both
// channels move a request when valid and ready are high at a rising edge.
// The block works on one request at a time; i_req.ready is low while it is busy.
// From the accepting edge to o_rsp.valid, every request ends with a read of
// the front entry, a read of the back entry and the output step. Add and
// remove at either end and the full/empty refusals first update the ring or
// set the status; unused ops go straight to the final reads. Contains and
// remove value first walk the entries up to the first match, or all of them
// on a miss; after a match, remove value closes the gap over the rest.
// A new request is taken in the cycle after the response is loaded; the search
// and shift loop walks one entry per cycle through the single store read port.
// The response sits in an output register, so a new request is taken while a
// response still waits; if the receiver stalls, the following response holds in
// its final step until the output register is free.
// Reset (synchronous, active low) empties the store; no clearing pass is needed.
`include "bounded_deque_bag_assert.svh"

module bounded_deque_bag (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bdb_req_if.sink          i_req,
    bdb_rsp_if.source        o_rsp
);

    // Sequencer and datapath state.
    logic                 r_busy;
    bdb_pkg::t_upc        r_upc;
    bdb_pkg::t_upc        n_upc;
    bdb_pkg::t_op         r_op;
    bdb_pkg::t_data       r_val;
    bdb_pkg::t_idx        r_head;
    bdb_pkg::t_cnt        r_count;
    bdb_pkg::t_cnt        r_idx;
    logic                 r_found;
    bdb_pkg::t_status     r_status;
    bdb_pkg::t_data       r_front;

    // Output register.
    logic                 r_ovalid;
    bdb_pkg::t_status     r_ostatus;
    logic                 r_ofound;
    bdb_pkg::t_data       r_ofront;
    bdb_pkg::t_data       r_oback;
    bdb_pkg::t_count      r_ocount;

    // Entry store port signals.
    logic                 ram_we;
    bdb_pkg::t_idx        ram_waddr;
    bdb_pkg::t_data       ram_wdata;
    logic                 ram_re;
    bdb_pkg::t_idx        ram_raddr;
    bdb_pkg::t_data       ram_rdata;

    // Decoded control word and datapath flags.
    bdb_pkg::t_uword      uw;
    bdb_pkg::t_cnt        idx1;
    bdb_pkg::t_cnt        idx2;
    bdb_pkg::t_idx        head_m1;
    bdb_pkg::t_idx        head_p1;
    logic                 accept;
    logic                 empty;
    logic                 full;
    logic                 hit;
    logic                 last;
    logic                 out_free;
    logic                 out_load;
    logic                 cond_ok;

    assign uw       = bdb_pkg::ucode(r_upc);
    assign accept   = i_req.valid && i_req.ready;
    assign idx1     = r_idx + bdb_pkg::t_cnt'(1);
    assign idx2     = r_idx + bdb_pkg::t_cnt'(2);
    assign empty    = (r_count == '0);
    assign full     = (r_count == bdb_pkg::t_cnt'(bdb_pkg::DEPTH));
    assign hit      = (ram_rdata == r_val);
    assign last     = (idx1 >= r_count);
    assign out_free = !r_ovalid || o_rsp.ready;
    assign out_load = r_busy && (uw.act == bdb_pkg::ACT_OUT) && out_free;
    assign head_m1  = (r_head == '0) ? bdb_pkg::t_idx'(bdb_pkg::DEPTH - 1)
                                     : r_head - bdb_pkg::t_idx'(1);
    assign head_p1  = (r_head == bdb_pkg::t_idx'(bdb_pkg::DEPTH - 1)) ? '0
                                     : r_head + bdb_pkg::t_idx'(1);

    // Jump condition and next step.
    always_comb begin
        unique case (uw.cond)
            bdb_pkg::C_NEVER:     cond_ok = 1'b0;
            bdb_pkg::C_ALWAYS:    cond_ok = 1'b1;
            bdb_pkg::C_SRCH_END:  cond_ok = hit || last;
            bdb_pkg::C_DEL_HIT:   cond_ok = r_found && (r_op == bdb_pkg::OP_REM_VALUE);
            bdb_pkg::C_SHIFT_END: cond_ok = last;
            bdb_pkg::C_OUT_FREE:  cond_ok = out_free;
            default:              cond_ok = 1'b0;
        endcase
        if (cond_ok) begin
            n_upc = uw.target;
        end else if (uw.loop) begin
            n_upc = r_upc;
        end else begin
            n_upc = r_upc + bdb_pkg::t_upc'(1);
        end
    end

    // Store read address selection.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_head;
        unique case (uw.rd)
            bdb_pkg::RD_NONE: begin
                ram_re = 1'b0;
            end
            bdb_pkg::RD_IDX: begin
                ram_re    = r_busy;
                ram_raddr = bdb_pkg::ring_pos(r_head, r_idx);
            end
            bdb_pkg::RD_IDX1: begin
                ram_re    = r_busy;
                ram_raddr = bdb_pkg::ring_pos(r_head, idx1);
            end
            bdb_pkg::RD_IDX2: begin
                ram_re    = r_busy && !last;
                ram_raddr = bdb_pkg::ring_pos(r_head, idx2);
            end
            bdb_pkg::RD_FRONT: begin
                ram_re    = r_busy && !empty;
                ram_raddr = r_head;
            end
            bdb_pkg::RD_BACK: begin
                ram_re    = r_busy && !empty;
                ram_raddr = bdb_pkg::ring_pos(r_head, r_count - bdb_pkg::t_cnt'(1));
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Store write address and data selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = head_m1;
        ram_wdata = r_val;
        unique case (uw.wr)
            bdb_pkg::WR_NONE: begin
                ram_we = 1'b0;
            end
            bdb_pkg::WR_FRONT: begin
                ram_we    = r_busy;
                ram_waddr = head_m1;
            end
            bdb_pkg::WR_BACK: begin
                ram_we    = r_busy;
                ram_waddr = bdb_pkg::ring_pos(r_head, r_count);
            end
            bdb_pkg::WR_SHIFT: begin
                ram_we    = r_busy && !last;
                ram_waddr = bdb_pkg::ring_pos(r_head, r_idx);
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state: sequencer, ring pointers, search index and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_upc    <= bdb_pkg::U_FIN_RF;
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_status <= bdb_pkg::ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (accept) begin
                r_busy   <= 1'b1;
                r_upc    <= bdb_pkg::dispatch(i_req.op, empty, full);
                r_idx    <= '0;
                r_found  <= 1'b0;
                r_status <= bdb_pkg::ST_OK;
            end else if (r_busy) begin
                r_upc <= n_upc;
                case (uw.act)
                    bdb_pkg::ACT_PUSH_F: begin
                        r_head  <= head_m1;
                        r_count <= r_count + bdb_pkg::t_cnt'(1);
                    end
                    bdb_pkg::ACT_PUSH_B: begin
                        r_count <= r_count + bdb_pkg::t_cnt'(1);
                    end
                    bdb_pkg::ACT_POP_F: begin
                        r_head  <= head_p1;
                        r_count <= r_count - bdb_pkg::t_cnt'(1);
                    end
                    bdb_pkg::ACT_POP_B: begin
                        r_count <= r_count - bdb_pkg::t_cnt'(1);
                    end
                    bdb_pkg::ACT_FULL: begin
                        r_status <= bdb_pkg::ST_FULL;
                    end
                    bdb_pkg::ACT_EMPTY: begin
                        r_status <= bdb_pkg::ST_EMPTY;
                    end
                    bdb_pkg::ACT_CMP: begin
                        if (hit) begin
                            r_found <= 1'b1;
                        end else if (!last) begin
                            r_idx <= idx1;
                        end
                    end
                    bdb_pkg::ACT_SHIFT: begin
                        if (last) begin
                            r_count <= r_count - bdb_pkg::t_cnt'(1);
                        end else begin
                            r_idx <= idx1;
                        end
                    end
                    bdb_pkg::ACT_OUT: begin
                        if (out_free) begin
                            r_busy <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers: request operands, captured front and the response.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.op;
            r_val <= i_req.value;
        end
        if (r_busy && (uw.act == bdb_pkg::ACT_CAP_F)) begin
            r_front <= empty ? '0 : ram_rdata;
        end
        if (out_load) begin
            r_ostatus <= r_status;
            r_ofound  <= r_found;
            r_ofront  <= r_front;
            r_oback   <= empty ? '0 : ram_rdata;
            r_ocount  <= bdb_pkg::t_count'(r_count);
        end
    end

    // Entry store.
    bdb_ram #(
        .WIDTH (bdb_pkg::DATA_W),
        .DEPTH (bdb_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Channel outputs.
    assign i_req.ready       = !r_busy;
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.found       = r_ofound;
    assign o_rsp.front_value = r_ofront;
    assign o_rsp.back_value  = r_oback;
    assign o_rsp.count       = r_ocount;

    // The held count never goes past the capacity.
    `BDB_ASSERT(a_count_bound, r_count <= bdb_pkg::t_cnt'(bdb_pkg::DEPTH), "count above depth")
    // The count only moves while a request is in progress.
    `BDB_ASSERT(a_count_idle, !r_busy |=> $stable(r_count), "count changed while idle")
    // The gap closing loop runs only after a match.
    `BDB_ASSERT(a_shift_found, r_busy && (r_upc == bdb_pkg::U_SHIFT) |-> r_found, "shift without match")
    // A match is never reported together with a refusal.
    `BDB_ASSERT(a_found_ok, o_rsp.valid && o_rsp.found |-> o_rsp.status == bdb_pkg::ST_OK, "found with bad status")

endmodule

// ===== tb/tb_bounded_deque_bag.sv =====
// Self-checking testbench of the bounded deque/bag with a scoreboard that mirrors its contents.
module tb_bounded_deque_bag;
    timeunit 1ns;
    timeprecision 1ps;

    import bdb_pkg::*;

    // Op codes the block treats as no operation.
    localparam t_op OP_UNUSED_LO = 3'd6;
    localparam t_op OP_UNUSED_HI = 3'd7;
    localparam int  POOL_SIZE    = 8;

    // One response as the block should present it.
    typedef struct {
        t_status status;
        logic    found;
        t_data   front_value;
        t_data   back_value;
        t_count  count;
    } deque_result_t;

    // Mirror of the deque contents and the queue of responses still owed.
    class deque_tracker;
        t_data         entries[DEPTH];
        int            head;
        int            held;
        deque_result_t owed_results[$];
        int            mismatches;

        function new();
            head = 0;
            held = 0;
            mismatches = 0;
        endfunction

        function int slot(int offset);
            return (head + offset) % DEPTH;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function t_data held_value(int offset);
            return entries[slot(offset)];
        endfunction

        // Apply one accepted request to the mirror and queue the response it owes.
        function void note_request(t_op op, t_data value);
            deque_result_t r;
            int hit;
            int i;
            r.status = ST_OK;
            r.found = 1'b0;
            case (op)
                OP_ADD_FRONT, OP_ADD_BACK: begin
                    if (held >= DEPTH) begin
                        r.status = ST_FULL;
                    end else if (op == OP_ADD_FRONT) begin
                        head = (head + DEPTH - 1) % DEPTH;
                        entries[head] = value;
                        held++;
                    end else begin
                        entries[slot(held)] = value;
                        held++;
                    end
                end
                OP_REM_FRONT, OP_REM_BACK, OP_CONTAINS, OP_REM_VALUE: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else if (op == OP_REM_FRONT) begin
                        head = slot(1);
                        held--;
                    end else if (op == OP_REM_BACK) begin
                        held--;
                    end else begin
                        // First occurrence wins; a removal closes the gap toward the front.
                        hit = -1;
                        for (i = 0; i < held; i++) begin
                            if (hit < 0 && entries[slot(i)] == value) begin
                                hit = i;
                            end
                        end
                        if (hit >= 0) begin
                            r.found = 1'b1;
                            if (op == OP_REM_VALUE) begin
                                for (i = hit; i + 1 < held; i++) begin
                                    entries[slot(i)] = entries[slot(i + 1)];
                                end
                                held--;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            r.front_value = (held == 0) ? '0 : entries[slot(0)];
            r.back_value  = (held == 0) ? '0 : entries[slot(held - 1)];
            r.count       = t_count'(held);
            owed_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, msg);
        endtask

        // Compare one accepted response with the oldest one owed.
        task check_response(t_status status, logic found, t_data front_value,
                            t_data back_value, t_count count);
            deque_result_t r;
            if (owed_results.size() == 0) begin
                report_mismatch("response arrived with no request outstanding");
            end else begin
                r = owed_results.pop_front();
                if (status !== r.status) begin
                    report_mismatch($sformatf("status %0d, want %0d", status, r.status));
                end
                if (found !== r.found) begin
                    report_mismatch($sformatf("found %0b, want %0b", found, r.found));
                end
                if (front_value !== r.front_value) begin
                    report_mismatch($sformatf("front %0d, want %0d",
                                              front_value, r.front_value));
                end
                if (back_value !== r.back_value) begin
                    report_mismatch($sformatf("back %0d, want %0d",
                                              back_value, r.back_value));
                end
                if (count !== r.count) begin
                    report_mismatch($sformatf("count %0d, want %0d", count, r.count));
                end
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdb_req_if req_ch();
    bdb_rsp_if rsp_ch();

    bounded_deque_bag uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    deque_tracker tracker = new();

    int    req_gap_max;
    int    rsp_gap_max;
    int    rsp_hold_cycles;
    t_data value_pool[POOL_SIZE];

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Record every accepted request.
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            tracker.note_request(req_ch.op, req_ch.value);
        end
    end

    // Check every accepted response.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_response(rsp_ch.status, rsp_ch.found, rsp_ch.front_value,
                                   rsp_ch.back_value, rsp_ch.count);
        end
    end

    // Receiver: a random stall before each response, or a long hold when asked.
    initial begin : receiver
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge i_clk);
                rsp_hold_cycles = 0;
            end else begin
                gap = $urandom_range(0, rsp_gap_max);
                if (gap > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Offer one request after a random gap and hold it until it is taken.
    task send_request(t_op op, t_data value);
        int gap;
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Stop offering and wait until every owed response has come back.
    task wait_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    function automatic t_data pick_value();
        if ($urandom_range(0, 9) < 6) begin
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return t_data'($urandom());
    endfunction

    // Operation mix; add_pct steers the fill level.
    function automatic t_op pick_op(int add_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return t_op'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        if (r < 3 + add_pct) begin
            return ($urandom_range(0, 1) != 0) ? OP_ADD_BACK : OP_ADD_FRONT;
        end
        case ($urandom_range(0, 3))
            0:       return OP_REM_FRONT;
            1:       return OP_REM_BACK;
            2:       return OP_CONTAINS;
            default: return OP_REM_VALUE;
        endcase
    endfunction

    // A run of random requests; searches often aim at a value that is held.
    task run_phase(int n_items, int add_pct, int req_max, int rsp_max);
        t_op   op;
        t_data value;
        int    k;
        req_gap_max = req_max;
        rsp_gap_max = rsp_max;
        for (k = 0; k < n_items; k++) begin
            op = pick_op(add_pct);
            value = pick_value();
            if ((op == OP_CONTAINS || op == OP_REM_VALUE) && tracker.held > 0 &&
                $urandom_range(0, 2) != 0) begin
                value = tracker.held_value($urandom_range(0, tracker.held - 1));
            end
            send_request(op, value);
        end
    endtask

    initial begin : stimulus
        int k;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_ADD_FRONT;
        req_ch.value <= '0;
        req_gap_max = 3;
        rsp_gap_max = 3;
        rsp_hold_cycles = 0;
        value_pool[0] = 32'sh0000_0000;
        value_pool[1] = -32'sd1;
        value_pool[2] = 32'sh8000_0000;
        value_pool[3] = 32'sh7fff_ffff;
        for (k = 4; k < POOL_SIZE; k++) begin
            value_pool[k] = t_data'($urandom());
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every refusal on an empty store, and an unused op.
        send_request(OP_REM_FRONT, 32'sd5);
        send_request(OP_REM_BACK, 32'sd5);
        send_request(OP_CONTAINS, 32'sd0);
        send_request(OP_REM_VALUE, 32'sd0);
        send_request(OP_UNUSED_LO, -32'sd1);

        // Fill from both ends with the extreme values, then overflow at each end.
        for (k = 0; k < DEPTH; k++) begin
            send_request((k % 2 == 0) ? OP_ADD_BACK : OP_ADD_FRONT, value_pool[k % 4]);
        end
        send_request(OP_ADD_FRONT, 32'sd123);
        send_request(OP_ADD_BACK, 32'sh8000_0000);

        // Search hit, removal of a value that occurs several times, miss, and pops.
        send_request(OP_CONTAINS, 32'sh7fff_ffff);
        send_request(OP_REM_VALUE, -32'sd1);
        send_request(OP_REM_VALUE, 32'sd77);
        send_request(OP_UNUSED_HI, 32'sh8000_0000);
        send_request(OP_REM_FRONT, 32'sd0);
        send_request(OP_REM_BACK, 32'sd0);

        // Random part under different fill tendencies and idling patterns.
        run_phase(200, 50, 0, 0);
        run_phase(200, 70, 15, 15);
        wait_until_drained();
        run_phase(200, 35, 3, 15);
        run_phase(200, 60, 15, 0);

        // Receiver holds off while the sender keeps offering, so the input stalls.
        rsp_hold_cycles = 300;
        run_phase(200, 50, 0, 0);
        run_phase(200, 25, 3, 3);
        wait_until_drained();
        run_phase(200, 55, 15, 15);

        wait_until_drained();
        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
